// ===== src/sqls_pkg.sv =====
package sqls_pkg;

    localparam logic [3:0] QL_UNUSED = 4'h0;
    localparam logic [3:0] QL_DNU    = 4'hF;

    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_IFACE = 2'd1;
    localparam logic [1:0] KIND_MODE  = 2'd2;

    localparam logic [1:0] MODE_NCO     = 2'd0;
    localparam logic [1:0] MODE_REFLOCK = 2'd1;
    localparam logic [1:0] MODE_UNSET   = 2'd2;

    localparam logic [2:0] REG_BLOCK_ENABLE = 3'd0;
    localparam logic [2:0] REG_INPUT_PORT   = 3'd1;
    localparam logic [2:0] REG_OUTPUT_PORT  = 3'd2;
    localparam logic [2:0] REG_ACCEPT_TG    = 3'd3;
    localparam logic [2:0] REG_SEND_TG      = 3'd4;
    localparam logic [2:0] REG_TG_MASK      = 3'd5;
    localparam logic [2:0] REG_TIMEOUT      = 3'd6;
    localparam logic [2:0] REG_MAX_PDUS     = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef struct packed {
        logic       opcode;
        logic [2:0] rx_port;
        logic [3:0] rx_ssm;
        logic       pll_lock;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] port;
        logic       port_valid;
        logic [3:0] tx_ssm;
        logic       tx_event;
        logic       mode;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       block_enable;
        logic [2:0] input_port;
        logic [3:0] output_port;
        logic       accept_tg_input;
        logic       send_tg_output;
        logic [7:0] tg_port_mask;
        logic [7:0] timeout_seconds;
        logic [7:0] max_pdus_per_second;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_IFACE,
        S_MODE,
        S_ANNOUNCE,
        S_BC_OUT,
        S_BC_TG,
        S_BC_END
    } t_state;

    function automatic logic [2:0] ql_rank(input logic [3:0] q);
        case (q)
            4'h2:    ql_rank = 3'd5;
            4'h4:    ql_rank = 3'd4;
            4'h8:    ql_rank = 3'd3;
            4'hB:    ql_rank = 3'd2;
            4'hF:    ql_rank = 3'd1;
            default: ql_rank = 3'd0;
        endcase
    endfunction

endpackage

// ===== src/sqls_if.sv =====
interface sqls_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/sqls_front.sv =====
module sqls_front #(
    parameter int NUM_PORTS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sqls_pkg::t_cfg i_cfg,
    sqls_if.sink           s_in,
    sqls_if.source         m_cmd
);
    import sqls_pkg::*;

    localparam int QD = 2;

    t_in_item   r_q [QD];
    logic [1:0] r_cnt;
    logic       r_wr;
    logic       r_rd;
    logic       push;
    logic       pop;
    logic       p_ok;
    logic       keep;

    always_comb begin
        p_ok = (32'(s_in.data.rx_port) < NUM_PORTS) &&
               ((s_in.data.rx_port == i_cfg.input_port) ||
                (i_cfg.accept_tg_input && i_cfg.tg_port_mask[s_in.data.rx_port]));
        keep = s_in.data.opcode || p_ok;
    end

    assign s_in.ready  = (r_cnt != 2'(QD));
    assign push        = s_in.valid && s_in.ready && keep;
    assign m_cmd.valid = (r_cnt != 2'd0);
    assign m_cmd.data  = r_q[r_rd];
    assign pop         = m_cmd.valid && m_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_q[r_wr] <= s_in.data;
    end
endmodule

// ===== src/sqls_back.sv =====
module sqls_back #(
    parameter int NUM_PORTS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sqls_pkg::t_cfg i_cfg,
    sqls_if.sink           s_cmd,
    sqls_if.source         m_out
);
    import sqls_pkg::*;

    localparam int PW = $clog2(NUM_PORTS + 1);
    localparam int IW = $clog2(NUM_PORTS);
    localparam logic [PW-1:0] NONE = PW'(NUM_PORTS);

    t_state        r_state, n_state;
    logic [3:0]    r_qual [NUM_PORTS];
    logic [31:0]   r_last [NUM_PORTS];
    logic [31:0]   r_sec;
    logic [PW-1:0] r_sel, r_prog, r_from, r_best, r_p, r_iface;
    logic [1:0]    r_mode;
    logic [1:0]    r_want;
    logic          r_lock;
    logic [3:0]    r_ann, r_bssm, r_bcssm;
    logic          r_bcev, r_sent;
    logic [7:0]    r_rounds;
    logic          r_ov;
    t_out_item     r_o;
    logic          r_pend;
    t_out_item     r_pdat;

    logic          emit;
    t_out_item     e;
    logic          done;
    logic          load;
    t_out_item     o_next;
    logic [IW-1:0] pi;
    logic [IW-1:0] rx_i;
    logic [3:0]    q, qn;
    logic [3:0]    ann_q;
    logic          bc_go;
    logic [PW-1:0] outp;
    logic          tgp;
    logic          stall;

    assign pi   = r_p[IW-1:0];
    assign rx_i = IW'(s_cmd.data.rx_port);
    assign outp = (32'(i_cfg.output_port) < NUM_PORTS) ? PW'(i_cfg.output_port) : NONE;
    assign tgp  = (32'(r_p) < 8) && i_cfg.tg_port_mask[3'(r_p)];
    assign stall = r_pend && r_ov && !m_out.ready;
    assign ann_q = r_lock ? r_bssm : QL_DNU;
    assign bc_go = (r_rounds < i_cfg.max_pdus_per_second) &&
                   ((ann_q != r_ann) || (r_from == NONE && ann_q != QL_UNUSED));

    assign s_cmd.ready = (r_state == S_IDLE) && !stall && !r_pend;
    assign m_out.valid = r_ov;
    assign m_out.data  = r_o;

    always_comb begin
        q  = r_qual[pi];
        qn = q;
        if (q != QL_UNUSED && q != QL_DNU &&
            (r_sec - r_last[pi]) >= 32'(i_cfg.timeout_seconds))
            qn = QL_DNU;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_cmd.valid && s_cmd.ready) begin
                    if (!s_cmd.data.opcode) begin
                        if (r_qual[rx_i] != s_cmd.data.rx_ssm)
                            n_state = S_SCAN;
                    end else if (i_cfg.block_enable) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN:     if (r_p == NONE) n_state = S_IFACE;
            S_IFACE:    if (!stall) n_state = S_MODE;
            S_MODE:     if (!stall) n_state = S_ANNOUNCE;
            S_ANNOUNCE: if (!stall) n_state = bc_go ? S_BC_OUT : S_BC_END;
            S_BC_OUT:   if (!stall) n_state = S_BC_TG;
            S_BC_TG:    if (!stall && (!i_cfg.send_tg_output || r_p == NONE - PW'(1) ||
                                       r_p == NONE)) n_state = S_BC_END;
            S_BC_END:   if (!stall) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        emit = 1'b0;
        e    = '0;
        e.port_valid = 1'b1;
        case (r_state)
            S_IFACE: begin
                if (r_best != r_sel || r_iface != r_prog) begin
                    emit = 1'b1;
                    e.kind = KIND_IFACE;
                    e.port_valid = (r_iface != NONE);
                    e.port = (r_iface != NONE) ? 3'(r_iface) : 3'd0;
                end else begin
                    e.port_valid = 1'b0;
                end
            end
            S_MODE: begin
                e.port_valid = 1'b0;
                if (r_want != r_mode) begin
                    emit = 1'b1;
                    e.kind = KIND_MODE;
                    e.mode = r_want[0];
                end
            end
            S_BC_OUT: begin
                if (outp != NONE && !(outp == r_sel && r_bcev)) begin
                    emit = 1'b1;
                    e.kind = KIND_TX;
                    e.port = 3'(outp);
                    e.tx_ssm = (outp == r_sel) ? QL_DNU : r_bcssm;
                    e.tx_event = (outp == r_sel) ? 1'b0 : r_bcev;
                end
            end
            S_BC_TG: begin
                if (i_cfg.send_tg_output && r_p != NONE && r_p != r_from && r_p != outp &&
                    tgp && !(r_p == r_sel && r_bcev)) begin
                    emit = 1'b1;
                    e.kind = KIND_TX;
                    e.port = 3'(r_p);
                    e.tx_ssm = (r_p == r_sel) ? QL_DNU : r_bcssm;
                    e.tx_event = (r_p == r_sel) ? 1'b0 : r_bcev;
                end
            end
            default: ;
        endcase
        done = (r_state == S_BC_END) && !stall;
        load = !stall && r_pend && (emit || done);
        o_next = r_pdat;
        o_next.last = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sec    <= '0;
            r_sel    <= NONE;
            r_prog   <= NONE;
            r_mode   <= MODE_UNSET;
            r_lock   <= 1'b0;
            r_ann    <= QL_UNUSED;
            r_rounds <= '0;
            r_ov     <= 1'b0;
            r_pend   <= 1'b0;
            r_p      <= '0;
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_qual[i] <= QL_UNUSED;
                r_last[i] <= '0;
            end
        end else begin
            if (load) begin
                r_o  <= o_next;
                r_ov <= 1'b1;
            end else if (r_ov && m_out.ready) begin
                r_ov <= 1'b0;
            end
            if (!stall && emit) begin
                r_pdat <= e;
                r_pend <= 1'b1;
            end else if (done && r_pend) begin
                r_pend <= 1'b0;
            end
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (s_cmd.valid && s_cmd.ready) begin
                        r_p    <= '0;
                        r_bssm <= QL_UNUSED;
                        r_best <= NONE;
                        if (!s_cmd.data.opcode) begin
                            r_last[rx_i] <= r_sec;
                            r_qual[rx_i] <= s_cmd.data.rx_ssm;
                            r_from <= PW'(s_cmd.data.rx_port);
                        end else begin
                            r_sec <= r_sec + 32'd1;
                            r_from <= NONE;
                            if (i_cfg.block_enable) begin
                                r_rounds <= '0;
                                r_lock   <= s_cmd.data.pll_lock;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_p != NONE) begin
                        if (qn != q) r_qual[pi] <= QL_DNU;
                        if (q != QL_UNUSED && ql_rank(qn) > ql_rank(r_bssm)) begin
                            r_bssm <= qn;
                            r_best <= r_p;
                        end
                        r_p <= r_p + PW'(1);
                    end else begin
                        if (r_bssm == QL_UNUSED || r_bssm == QL_DNU) begin
                            r_want <= MODE_NCO;  r_iface <= NONE;
                        end else if (32'(r_best) == 32'(i_cfg.input_port)) begin
                            r_want <= MODE_REFLOCK; r_iface <= NONE;
                        end else begin
                            r_want <= MODE_NCO;  r_iface <= r_best;
                        end
                    end
                end
                S_IFACE: if (!stall && (r_best != r_sel || r_iface != r_prog)) begin
                    r_sel  <= r_best;
                    r_prog <= r_iface;
                    r_lock <= 1'b0;
                end
                S_MODE: if (!stall && r_want != r_mode) begin
                    r_mode <= r_want;
                    r_lock <= 1'b0;
                end
                S_ANNOUNCE: if (!stall) begin
                    r_bcssm <= ann_q;
                    r_sent  <= 1'b0;
                    r_p     <= '0;
                    if (ann_q != r_ann) begin
                        r_ann  <= ann_q;
                        r_bcev <= 1'b1;
                    end else begin
                        r_bcev <= 1'b0;
                    end
                end
                S_BC_OUT: if (!stall && emit) r_sent <= 1'b1;
                S_BC_TG: if (!stall) begin
                    if (emit) r_sent <= 1'b1;
                    if (n_state == S_BC_END) begin
                        if ((emit || r_sent) && r_rounds != 8'hFF)
                            r_rounds <= r_rounds + 8'd1;
                    end else begin
                        r_p <= r_p + PW'(1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== src/synce_quality_level_selector_core.sv =====
// Quality-level selector: a front stage filters received messages and ticks
// into a two-beat queue, and a back sequencer scans all ports one per cycle,
// then issues PLL commands and message beats one per cycle unless the
// receiver stalls the result register. A tick with the block enabled, or a
// changed code, holds the back stage through the scan, PLL command and
// announce states, the message round states and any receiver stalls.
// Dropped messages and unchanged codes leave the back stage idle.
module synce_quality_level_selector_core #(
    parameter int NUM_PORTS = 8
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic [sqls_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [sqls_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    sqls_if.sink                            s_in,
    sqls_if.source                          m_out
);
    import sqls_pkg::*;

    t_cfg r_cfg;

    sqls_if #(.T(t_in_item)) cmd_if ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{1'b0, 3'd0, 4'd8, 1'b0, 1'b0, 8'd0, 8'd5, 8'd10};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_ENABLE: r_cfg.block_enable        <= i_cfg_data[0];
                REG_INPUT_PORT:   r_cfg.input_port          <= i_cfg_data[2:0];
                REG_OUTPUT_PORT:  r_cfg.output_port         <= i_cfg_data[3:0];
                REG_ACCEPT_TG:    r_cfg.accept_tg_input     <= i_cfg_data[0];
                REG_SEND_TG:      r_cfg.send_tg_output      <= i_cfg_data[0];
                REG_TG_MASK:      r_cfg.tg_port_mask        <= i_cfg_data;
                REG_TIMEOUT:      r_cfg.timeout_seconds     <= i_cfg_data;
                REG_MAX_PDUS:     r_cfg.max_pdus_per_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sqls_front #(.NUM_PORTS(NUM_PORTS)) u_front (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .s_in, .m_cmd(cmd_if.source)
    );

    sqls_back #(.NUM_PORTS(NUM_PORTS)) u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .s_cmd(cmd_if.sink), .m_out
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("result beat changed while stalled");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> m_out.data.kind != 2'd3)
        else $error("result kind out of range");
endmodule
